// ===== rtl/smpm_pkg.sv =====
// Package for the softmax partial merge unit: sizes, scale tables,
// controller command and status types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package smpm_pkg;

    localparam int VECTOR_DEPTH = 64;
    localparam int PART_DEPTH   = 16;
    localparam int PART_W       = $clog2(PART_DEPTH);
    localparam int ELEM_W       = $clog2(VECTOR_DEPTH);
    localparam int ADDR_W       = PART_W + ELEM_W;
    localparam int STORE_DEPTH  = PART_DEPTH * VECTOR_DEPTH;
    localparam int DIV_STEPS    = 53;
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_PART_NRM = 3'd1;
    localparam logic [2:0] ERR_LENGTH   = 3'd2;
    localparam logic [2:0] ERR_PARTS    = 3'd3;
    localparam logic [2:0] ERR_TOTAL    = 3'd4;

    typedef logic [0:255][16:0] t_frac_rom;
    typedef logic [0:15][16:0]  t_int_rom;

    // exp(-k) in Q1.16; entries past eleven only feed scales that are forced to zero
    localparam t_int_rom INT_ROM = '{
        17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162,
        17'd60, 17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0};

    // shift-and-subtract quotient of non-negative operands
    function automatic longint udiv_shift(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (longint'(1) <<< b);
            end
        end
        return quo;
    endfunction

    // exp(-f/256) in Q1.16 via a Q0.30 Taylor series, built at elaboration
    function automatic t_frac_rom frac_rom_build();
        t_frac_rom rom;
        longint x;
        longint term;
        longint sum;
        for (int f = 0; f < 256; f++) begin
            x    = longint'(f) <<< 22;
            term = longint'(1) <<< 30;
            sum  = term;
            for (int n = 1; n <= 16; n++) begin
                term = udiv_shift((term * x) >>> 30, longint'(n));
                if ((n % 2) == 1) sum = sum - term;
                else sum = sum + term;
            end
            rom[f] = 17'((sum + 64'sd8192) >>> 14);
        end
        return rom;
    endfunction

    localparam t_frac_rom FRAC_ROM = frac_rom_build();

    typedef enum logic [3:0] {
        OP_IDLE, OP_SC_A, OP_SC_B, OP_SC_C, OP_SC_D, OP_CHECK, OP_RD, OP_MUL,
        OP_ACC, OP_DLD, OP_DIV, OP_DFIN, OP_OUT, OP_ERR
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              load;
        logic              clr;
        logic [PART_W-1:0] part;
        logic [ELEM_W-1:0] elem;
    } t_cmd;

    typedef struct packed {
        logic              fin;
        logic              err_now;
        logic              norm_bad;
        logic [PART_W:0]   parts;
        logic [ELEM_W:0]   len;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/smpm_in_if.sv =====
// Input item channel of the softmax partial merge unit.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface smpm_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] part_max_logit;
    logic [31:0]        part_normalizer;
    logic signed [31:0] numerator_value;
    logic               last_part;
    modport source(output valid, part_max_logit, part_normalizer, numerator_value,
                   last_part, input ready);
    modport sink(input valid, part_max_logit, part_normalizer, numerator_value,
                 last_part, output ready);
endinterface
`default_nettype wire

// ===== rtl/smpm_out_if.sv =====
// Result item channel of the softmax partial merge unit.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface smpm_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         element_index;
    logic signed [23:0] merged_max_logit;
    logic [31:0]        merged_normalizer;
    logic signed [31:0] merged_numerator;
    logic signed [31:0] merged_value;
    logic [2:0]         error_code;
    logic               last;
    modport source(output valid, element_index, merged_max_logit, merged_normalizer,
                   merged_numerator, merged_value, error_code, last, input ready);
    modport sink(input valid, element_index, merged_max_logit, merged_normalizer,
                 merged_numerator, merged_value, error_code, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/smpm_cfg_if.sv =====
// Configuration write channel: vector_length register.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface smpm_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/smpm_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module smpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/smpm_datapath.sv =====
// Datapath: part stores, element store, scale, accumulation and divider.
// Depends on smpm_pkg, smpm_in_if, smpm_out_if, smpm_cfg_if and smpm_ram.
`timescale 1ns / 1ps
`default_nettype none
module smpm_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire smpm_pkg::t_cmd i_cmd,
    output smpm_pkg::t_sts     o_sts,
    smpm_in_if.sink            i_in,
    smpm_cfg_if.sink           i_cfg,
    smpm_out_if.source         o_out
);
    import smpm_pkg::*;

    logic [6:0]          r_vlen;
    logic [ELEM_W:0]     r_held;
    logic [ELEM_W-1:0]   r_elem_cnt;
    logic [PART_W:0]     r_part_cnt;
    logic [2:0]          r_err;
    logic signed [23:0]  r_rmax;
    logic [52:0]         r_nsum;

    logic signed [23:0]  logit_st [PART_DEPTH];
    logic [31:0]         weight_st [PART_DEPTH];
    logic [16:0]         scale_st [PART_DEPTH];
    logic [33:0]         r_prod_s;
    logic                r_big;
    logic [16:0]         r_s;
    logic [48:0]         r_prodw;
    logic signed [49:0]  r_prode;
    logic signed [52:0]  r_acc;
    logic                r_neg;
    logic [31:0]         r_rem;
    logic [52:0]         r_quo;
    logic [31:0]         r_num_sat;
    logic [31:0]         r_val;

    logic [ELEM_W:0]     eff_len;
    logic [ELEM_W:0]     cur_len;
    logic                first;
    logic                stored;
    logic [ELEM_W:0]     idx_inc;
    logic                wrap;
    logic [ELEM_W-1:0]   n_elem_cnt;
    logic [PART_W:0]     n_part_cnt;
    logic [2:0]          load_code;
    logic [2:0]          n_err;
    logic                fin;
    logic [24:0]         diff;
    logic [7:0]          ip;
    logic [16:0]         s_val;
    logic [52:0]         mag;
    logic [32:0]         t_rem;
    logic                ge;
    logic [31:0]         norm;
    logic [31:0]         ram_rdata;
    logic [ADDR_W-1:0]   raddr;

    function automatic logic [31:0] sat32(input logic neg, input logic [52:0] m);
        logic [31:0] res;
        if (neg) begin
            res = (m > 53'h80000000) ? 32'h80000000 : 32'(-m);
        end else begin
            res = (m > 53'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
        end
        return res;
    endfunction

    assign i_cfg.ready = 1'b1;

    // load phase
    always_comb begin
        if (r_vlen == 7'd0) eff_len = (ELEM_W+1)'(1);
        else if (r_vlen > 7'(VECTOR_DEPTH)) eff_len = (ELEM_W+1)'(VECTOR_DEPTH);
        else eff_len = (ELEM_W+1)'(r_vlen);
        first   = (r_elem_cnt == '0) && (r_part_cnt == '0);
        cur_len = first ? eff_len : r_held;
        stored  = r_part_cnt < (PART_W+1)'(PART_DEPTH);
        idx_inc = {1'b0, r_elem_cnt} + (ELEM_W+1)'(1);
        wrap    = idx_inc >= cur_len;
        n_elem_cnt = wrap ? '0 : idx_inc[ELEM_W-1:0];
        n_part_cnt = (wrap && r_part_cnt <= (PART_W+1)'(PART_DEPTH)) ?
                     r_part_cnt + (PART_W+1)'(1) : r_part_cnt;
        load_code = ERR_NONE;
        if (r_elem_cnt == '0) begin
            if (!stored) load_code = ERR_PARTS;
            else if (i_in.part_normalizer == 32'd0) load_code = ERR_PART_NRM;
        end
        fin   = i_cmd.load && i_in.last_part;
        n_err = (r_err != ERR_NONE) ? r_err : load_code;
        if (fin && n_elem_cnt != '0 && n_err == ERR_NONE) n_err = ERR_LENGTH;
    end

    assign norm = r_nsum[47:16];

    always_comb begin
        o_sts.fin      = fin;
        o_sts.err_now  = n_err != ERR_NONE;
        o_sts.norm_bad = (r_nsum[52:16] == '0) || (r_nsum[52:48] != '0);
        o_sts.parts    = (r_part_cnt > (PART_W+1)'(PART_DEPTH)) ?
                         (PART_W+1)'(PART_DEPTH) : r_part_cnt;
        o_sts.len      = r_held;
    end

    // control state of the stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen     <= 7'(VECTOR_DEPTH);
            r_held     <= (ELEM_W+1)'(1);
            r_elem_cnt <= '0;
            r_part_cnt <= '0;
            r_err      <= ERR_NONE;
            r_rmax     <= '0;
            r_nsum     <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_vlen <= i_cfg.data;
            end
            if (i_cmd.clr) begin
                r_held     <= (ELEM_W+1)'(1);
                r_elem_cnt <= '0;
                r_part_cnt <= '0;
                r_err      <= ERR_NONE;
                r_rmax     <= '0;
                r_nsum     <= '0;
            end else if (i_cmd.load) begin
                r_held     <= cur_len;
                r_elem_cnt <= n_elem_cnt;
                r_part_cnt <= n_part_cnt;
                r_err      <= n_err;
                if (r_elem_cnt == '0 && stored &&
                    (r_part_cnt == '0 || i_in.part_max_logit > r_rmax)) begin
                    r_rmax <= i_in.part_max_logit;
                end
            end else if (i_cmd.op == OP_SC_D) begin
                r_nsum <= r_nsum + 53'(r_prodw);
            end else if (i_cmd.op == OP_CHECK && o_sts.norm_bad) begin
                r_err <= ERR_TOTAL;
            end
        end
    end

    always_comb begin
        diff  = {r_rmax[23], r_rmax} - {logit_st[i_cmd.part][23], logit_st[i_cmd.part]};
        ip    = diff[23:16];
        s_val = r_big ? 17'd0 : 17'((r_prod_s + 34'd32768) >> 16);
        mag   = r_acc[52] ? 53'(-r_acc) : 53'(r_acc);
        t_rem = {r_rem, r_quo[52]};
        ge    = t_rem >= {1'b0, norm};
    end

    // payload registers of the merge pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && stored && r_elem_cnt == '0) begin
            logit_st[r_part_cnt[PART_W-1:0]]  <= i_in.part_max_logit;
            weight_st[r_part_cnt[PART_W-1:0]] <= i_in.part_normalizer;
        end
        case (i_cmd.op)
            OP_SC_A: begin
                r_big    <= ip >= 8'd12;
                r_prod_s <= INT_ROM[ip[3:0]] * FRAC_ROM[diff[15:8]];
            end
            OP_SC_B: begin
                r_s                    <= s_val;
                scale_st[i_cmd.part]   <= s_val;
            end
            OP_SC_C: r_prodw <= r_s * weight_st[i_cmd.part];
            OP_RD: begin
                if (i_cmd.part == '0) r_acc <= '0;
            end
            OP_MUL: r_prode <= $signed({1'b0, scale_st[i_cmd.part]}) * $signed(ram_rdata);
            OP_ACC: r_acc <= r_acc + 53'(r_prode);
            OP_DLD: begin
                r_neg     <= r_acc[52];
                r_rem     <= '0;
                r_quo     <= {mag[52:16], 16'd0};
                r_num_sat <= sat32(r_acc[52], {16'd0, mag[52:16]});
            end
            OP_DIV: begin
                r_rem <= ge ? 32'(t_rem - {1'b0, norm}) : t_rem[31:0];
                r_quo <= {r_quo[51:0], ge};
            end
            OP_DFIN: r_val <= sat32(r_neg, r_quo);
            default: ;
        endcase
    end

    assign raddr = {i_cmd.part, i_cmd.elem};

    smpm_ram #(
        .WIDTH(32),
        .DEPTH(STORE_DEPTH)
    ) u_elem_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && stored),
        .i_waddr ({r_part_cnt[PART_W-1:0], r_elem_cnt}),
        .i_wdata (i_in.numerator_value),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (i_cmd.op == OP_ERR) begin
            o_out.element_index     = '0;
            o_out.merged_max_logit  = '0;
            o_out.merged_normalizer = '0;
            o_out.merged_numerator  = '0;
            o_out.merged_value      = '0;
            o_out.error_code        = r_err;
            o_out.last              = 1'b1;
        end else begin
            o_out.element_index     = i_cmd.elem;
            o_out.merged_max_logit  = r_rmax;
            o_out.merged_normalizer = norm;
            o_out.merged_numerator  = r_num_sat;
            o_out.merged_value      = r_val;
            o_out.error_code        = ERR_NONE;
            o_out.last              = ({1'b0, i_cmd.elem} + (ELEM_W+1)'(1)) == r_held;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/smpm_ctrl.sv =====
// Controller: sequences load, scale pass, per-element accumulate, divide, output.
// Depends on smpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smpm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire smpm_pkg::t_sts i_sts,
    output smpm_pkg::t_cmd      o_cmd
);
    import smpm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SC_A, S_SC_B, S_SC_C, S_SC_D, S_CHECK, S_RD, S_MUL, S_ACC,
        S_DLD, S_DIV, S_DFIN, S_OUT, S_ERR
    } t_state;

    t_state            r_state, n_state;
    logic [PART_W-1:0] r_k, n_k;
    logic [ELEM_W-1:0] r_i, n_i;
    logic [5:0]        r_cnt, n_cnt;
    logic              last_k;
    logic              last_i;
    logic              clr;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = (r_state == S_OUT) || (r_state == S_ERR);
    assign last_k = {1'b0, r_k} == i_sts.parts - (PART_W+1)'(1);
    assign last_i = ({1'b0, r_i} + (ELEM_W+1)'(1)) == i_sts.len;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_cnt   = r_cnt;
        clr     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.fin) begin
                    n_state = i_sts.err_now ? S_ERR : S_SC_A;
                    n_k     = '0;
                end
            end
            S_SC_A: n_state = S_SC_B;
            S_SC_B: n_state = S_SC_C;
            S_SC_C: n_state = S_SC_D;
            S_SC_D: begin
                if (last_k) begin
                    n_state = S_CHECK;
                end else begin
                    n_k     = r_k + PART_W'(1);
                    n_state = S_SC_A;
                end
            end
            S_CHECK: begin
                n_state = i_sts.norm_bad ? S_ERR : S_RD;
                n_k     = '0;
                n_i     = '0;
            end
            S_RD:  n_state = S_MUL;
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                if (last_k) begin
                    n_state = S_DLD;
                end else begin
                    n_k     = r_k + PART_W'(1);
                    n_state = S_RD;
                end
            end
            S_DLD: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_STEPS - 1)) n_state = S_DFIN;
            end
            S_DFIN: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_k = '0;
                    if (last_i) begin
                        clr     = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + ELEM_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_ERR: begin
                if (i_out_ready) begin
                    clr     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        o_cmd.load = o_in_ready && i_in_valid;
        o_cmd.clr  = clr;
        o_cmd.part = r_k;
        o_cmd.elem = r_i;
        unique case (r_state)
            S_IDLE:  o_cmd.op = OP_IDLE;
            S_SC_A:  o_cmd.op = OP_SC_A;
            S_SC_B:  o_cmd.op = OP_SC_B;
            S_SC_C:  o_cmd.op = OP_SC_C;
            S_SC_D:  o_cmd.op = OP_SC_D;
            S_CHECK: o_cmd.op = OP_CHECK;
            S_RD:    o_cmd.op = OP_RD;
            S_MUL:   o_cmd.op = OP_MUL;
            S_ACC:   o_cmd.op = OP_ACC;
            S_DLD:   o_cmd.op = OP_DLD;
            S_DIV:   o_cmd.op = OP_DIV;
            S_DFIN:  o_cmd.op = OP_DFIN;
            S_OUT:   o_cmd.op = OP_OUT;
            S_ERR:   o_cmd.op = OP_ERR;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output both open");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt < 6'(DIV_STEPS))
        else $error("divider step count overrun");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |=> o_in_ready)
        else $error("merge end did not return to idle");
    a_part_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC || r_state == S_SC_D) |-> {1'b0, r_k} < i_sts.parts)
        else $error("part index beyond stored parts");
`endif
endmodule
`default_nettype wire

// ===== rtl/softmax_partial_merge_unit.sv =====
// Softmax partial merge unit: loads one element item per cycle while idle.
// On the item marked last_part the block merges: a scale pass over the P stored
// parts and a check, then per element an accumulation over the parts, a division
// and an output item held until ready; an error gives one item.
// Reset (synchronous, active low) clears counters, error, max and normalizer sum.
// Depends on smpm_pkg, smpm_in_if, smpm_out_if, smpm_cfg_if, smpm_ctrl, smpm_datapath.
`timescale 1ns / 1ps
`default_nettype none
module softmax_partial_merge_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    smpm_in_if.sink    i_in,
    smpm_cfg_if.sink   i_cfg,
    smpm_out_if.source o_out
);
    import smpm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    smpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    smpm_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire
